/* src/get_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// get_pkg
// Shared types and constants of the gradient edge threshold unit.
// ----------------------------------------------------------------------------
package get_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 10;
    localparam int CFG_AW    = 1;
    localparam int SQ_W      = 16;
    localparam int SUM_W     = 17;
    localparam int ROOT_W    = 9;
    localparam int SQRT_STG  = 9;
    localparam int CFG_SIZE_RST = 512;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_AW-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_AW-1:0] REG_COLS = 1'b1;

    localparam logic [PIX_W-1:0] LEVEL_EDGE = 8'h00;
    localparam logic [PIX_W-1:0] LEVEL_BG   = 8'hFF;
    localparam logic [PIX_W-1:0] MAG_SAT    = 8'hFF;
    localparam logic [PIX_W-1:0] MIN_RST    = 8'hFF;
    localparam logic [PIX_W-1:0] MAX_RST    = 8'h00;

    typedef struct packed {
        logic is_read;
        logic interior;
        logic last;
    } t_item_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] left;
    } t_item_pix;

    typedef struct packed {
        logic full;
        logic almost_full;
    } t_fifo_status;

endpackage

/* src/gradient_edge_threshold_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_edge_threshold_unit
// Gradient magnitude edge detector with a half-range threshold.
// ----------------------------------------------------------------------------
// A command word is taken when i_start is high and o_busy is low. Op load
// writes one grey pixel of the frame in raster order; op readout asks for the
// next output pixel. Loads after the frame is complete and readouts before
// it is complete are dropped. Each readout returns one word on o_level and
// o_last_pixel, marked by o_strobe for one cycle; the receiver has no stall.
// One word is accepted per cycle while the four-entry command queue has room.
// The first readout of a frame waits for the 9-stage square root pipeline to
// drain into the magnitude memory; later ones stream one per cycle. Register
// writes on i_cfg_we set rows or cols and restart the frame; the user must
// make them only while the unit is idle, and the unit does not enforce it.
// Reset sets both sizes to 512 and empties the pipeline; the memories are not
// cleared and need no sweep.
// ----------------------------------------------------------------------------
module gradient_edge_threshold_unit #(
    parameter int MAX_ROWS = 512,
    parameter int MAX_COLS = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_op,
    input  logic [get_pkg::PIX_W-1:0]         i_pixel,
    input  logic                              i_cfg_we,
    input  logic [get_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [get_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                              o_strobe,
    output logic [get_pkg::PIX_W-1:0]         o_level,
    output logic                              o_last_pixel
);
    import get_pkg::*;

    localparam int AW     = $clog2(MAX_ROWS) + $clog2(MAX_COLS);
    localparam int CTL_W  = $bits(t_item_ctl);
    localparam int PIXS_W = $bits(t_item_pix);
    localparam int Q_W    = CTL_W + PIXS_W + AW;
    localparam int Q_DEPTH = 4;

    t_fifo_status  fifo_status;
    logic          push;
    t_item_ctl     f_ctl;
    t_item_pix     f_pix;
    logic [AW-1:0] f_addr;
    logic [Q_W-1:0] q_in;
    logic [Q_W-1:0] q_out;
    logic          q_empty;
    logic          pop;
    t_item_ctl     b_ctl;
    t_item_pix     b_pix;
    logic [AW-1:0] b_addr;

    get_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_op       (i_op),
        .i_pixel    (i_pixel),
        .o_busy     (o_busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_fifo     (fifo_status),
        .o_push     (push),
        .o_ctl      (f_ctl),
        .o_pix      (f_pix),
        .o_addr     (f_addr)
    );

    assign q_in = {f_ctl, f_pix, f_addr};

    get_fifo #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (q_in),
        .i_pop    (pop),
        .o_data   (q_out),
        .o_empty  (q_empty),
        .o_status (fifo_status)
    );

    assign {b_ctl, b_pix, b_addr} = q_out;

    get_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (i_cfg_we),
        .i_empty      (q_empty),
        .i_ctl        (b_ctl),
        .i_pix        (b_pix),
        .i_addr       (b_addr),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_level      (o_level),
        .o_last_pixel (o_last_pixel)
    );

endmodule

/* src/get_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// get_ram
// Generic simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module get_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/get_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// get_fifo
// Short show-ahead queue between the front and the back.
// ----------------------------------------------------------------------------
module get_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output logic                 o_empty,
    output get_pkg::t_fifo_status o_status
);
    import get_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data               = r_mem[r_rd_ptr];
    assign o_empty              = (r_count == '0);
    assign o_status.full        = (r_count >= CW'(DEPTH));
    assign o_status.almost_full = (r_count >= CW'(DEPTH - 1));

endmodule

/* src/get_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// get_sqrt
// Pipelined floor square root, one result bit per stage, with a tag alongside.
// ----------------------------------------------------------------------------
module get_sqrt #(
    parameter int TAG_W = 18
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [get_pkg::SUM_W-1:0]  i_value,
    input  logic [TAG_W-1:0]           i_tag,
    output logic                       o_valid,
    output logic [get_pkg::ROOT_W-1:0] o_root,
    output logic [TAG_W-1:0]           o_tag,
    output logic                       o_active
);
    import get_pkg::*;

    logic [SQRT_STG-1:0] r_valid;
    logic [SUM_W-1:0]    r_v    [SQRT_STG];
    logic [SUM_W-1:0]    r_root [SQRT_STG];
    logic [TAG_W-1:0]    r_tag  [SQRT_STG];

    for (genvar g = 0; g < SQRT_STG; g++) begin : g_stage
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STG - 1 - g));

        logic             cur_valid;
        logic [SUM_W-1:0] cur_v;
        logic [SUM_W-1:0] cur_root;
        logic [TAG_W-1:0] cur_tag;
        logic [SUM_W:0]   trial;
        logic             take;

        if (g == 0) begin : g_in
            assign cur_valid = i_valid;
            assign cur_v     = i_value;
            assign cur_root  = '0;
            assign cur_tag   = i_tag;
        end else begin : g_chain
            assign cur_valid = r_valid[g-1];
            assign cur_v     = r_v[g-1];
            assign cur_root  = r_root[g-1];
            assign cur_tag   = r_tag[g-1];
        end

        assign trial = {1'b0, cur_root} + {1'b0, BIT};
        assign take  = ({1'b0, cur_v} >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else begin
                r_valid[g] <= cur_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[g] <= cur_tag;
            if (take) begin
                r_v[g]    <= cur_v - trial[SUM_W-1:0];
                r_root[g] <= (cur_root >> 1) + BIT;
            end else begin
                r_v[g]    <= cur_v;
                r_root[g] <= cur_root >> 1;
            end
        end
    end

    assign o_valid  = r_valid[SQRT_STG-1];
    assign o_root   = r_root[SQRT_STG-1][ROOT_W-1:0];
    assign o_tag    = r_tag[SQRT_STG-1];
    assign o_active = |r_valid;

endmodule

/* src/get_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// get_front
// Accepts commands, tracks the raster position and frame state, fetches the
// pixel above and to the left, and queues the work for the back.
// ----------------------------------------------------------------------------
module get_front #(
    parameter int MAX_ROWS = 512,
    parameter int MAX_COLS = 512
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_start,
    input  logic                                             i_op,
    input  logic [get_pkg::PIX_W-1:0]                        i_pixel,
    output logic                                             o_busy,
    input  logic                                             i_cfg_we,
    input  logic [get_pkg::CFG_AW-1:0]                       i_cfg_addr,
    input  logic [get_pkg::CFG_W-1:0]                        i_cfg_data,
    input  get_pkg::t_fifo_status                            i_fifo,
    output logic                                             o_push,
    output get_pkg::t_item_ctl                               o_ctl,
    output get_pkg::t_item_pix                               o_pix,
    output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0]     o_addr
);
    import get_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;
    localparam int SW = ((CFG_W > RW) ? ((CFG_W > CW) ? CFG_W : CW)
                                      : ((RW > CW) ? RW : CW)) + 1;
    localparam int ROW_RST_LAST = ((CFG_SIZE_RST > MAX_ROWS) ? MAX_ROWS : CFG_SIZE_RST) - 1;
    localparam int COL_RST_LAST = ((CFG_SIZE_RST > MAX_COLS) ? MAX_COLS : CFG_SIZE_RST) - 1;

    function automatic logic [SW-1:0] last_index(input logic [SW-1:0] v,
                                                 input logic [SW-1:0] hi);
        logic [SW-1:0] res;
        if (v < SW'(2)) begin
            res = SW'(1);
        end else if (v > hi) begin
            res = hi - 1'b1;
        end else begin
            res = v - 1'b1;
        end
        return res;
    endfunction

    logic [RW-1:0]    r_last_row;
    logic [CW-1:0]    r_last_col;
    logic [RW-1:0]    r_row;
    logic [CW-1:0]    r_col;
    logic             r_ready;
    logic [PIX_W-1:0] r_left;
    logic             r_s1_valid;
    t_item_ctl        r_s1_ctl;
    logic [PIX_W-1:0] r_s1_pixel;
    logic [PIX_W-1:0] r_s1_left;
    logic [AW-1:0]    r_s1_addr;

    logic             accept;
    logic             load_take;
    logic             read_take;
    logic             need_mag;
    logic             row_end;
    logic             col_end;
    logic [PIX_W-1:0] above;
    logic [SW-1:0]    cfg_ext;

    assign o_busy    = !i_rst_n || i_fifo.full || (i_fifo.almost_full && r_s1_valid);
    assign accept    = i_start && !o_busy;
    assign load_take = accept && (i_op == OP_LOAD) && !r_ready;
    assign read_take = accept && (i_op == OP_READ) && r_ready;
    assign need_mag  = (r_row != '0) && (r_col != '0);
    assign row_end   = (r_row == r_last_row);
    assign col_end   = (r_col == r_last_col);
    assign cfg_ext   = SW'(i_cfg_data);

    // row above, read-first so the old pixel comes back while the new one goes in
    get_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (load_take),
        .i_waddr (r_col),
        .i_wdata (i_pixel),
        .i_raddr (r_col),
        .o_rdata (above)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_row <= RW'(ROW_RST_LAST);
            r_last_col <= CW'(COL_RST_LAST);
            r_row      <= '0;
            r_col      <= '0;
            r_ready    <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= (load_take && need_mag) || read_take;
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_ROWS) begin
                    r_last_row <= RW'(last_index(cfg_ext, SW'(MAX_ROWS)));
                end else begin
                    r_last_col <= CW'(last_index(cfg_ext, SW'(MAX_COLS)));
                end
                r_row   <= '0;
                r_col   <= '0;
                r_ready <= 1'b0;
            end else if (load_take || read_take) begin
                if (col_end) begin
                    r_col <= '0;
                    if (row_end) begin
                        r_row   <= '0;
                        r_ready <= load_take;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_take) begin
            r_left <= i_pixel;
        end
        if (accept) begin
            r_s1_ctl.is_read  <= (i_op == OP_READ);
            r_s1_ctl.interior <= need_mag && !row_end && !col_end;
            r_s1_ctl.last     <= row_end && col_end;
            r_s1_pixel        <= i_pixel;
            r_s1_left         <= r_left;
            r_s1_addr         <= {r_row, r_col};
        end
    end

    assign o_push      = r_s1_valid;
    assign o_ctl       = r_s1_ctl;
    assign o_pix.pixel = r_s1_pixel;
    assign o_pix.above = above;
    assign o_pix.left  = r_s1_left;
    assign o_addr      = r_s1_addr;

endmodule

/* src/get_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// get_back
// Computes and stores gradient magnitudes with running extremes, and answers
// readout words with the thresholded level.
// ----------------------------------------------------------------------------
module get_back #(
    parameter int MAX_ROWS = 512,
    parameter int MAX_COLS = 512
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_restart,
    input  logic                                         i_empty,
    input  get_pkg::t_item_ctl                           i_ctl,
    input  get_pkg::t_item_pix                           i_pix,
    input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] i_addr,
    output logic                                         o_pop,
    output logic                                         o_strobe,
    output logic [get_pkg::PIX_W-1:0]                    o_level,
    output logic                                         o_last_pixel
);
    import get_pkg::*;

    localparam int AW = $clog2(MAX_ROWS) + $clog2(MAX_COLS);

    logic             r_a_valid;
    logic [SUM_W-1:0] r_a_sum;
    logic [AW-1:0]    r_a_addr;
    logic             r_r1_valid;
    logic             r_r1_interior;
    logic             r_r1_last;
    logic [PIX_W-1:0] r_max;
    logic [PIX_W-1:0] r_min;
    logic             r_strobe;
    logic [PIX_W-1:0] r_level;
    logic             r_last;

    logic              load_busy;
    logic              pop_load;
    logic              pop_read;
    logic [PIX_W-1:0]  dx;
    logic [PIX_W-1:0]  dy;
    logic [SQ_W-1:0]   sq_x;
    logic [SQ_W-1:0]   sq_y;
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [AW-1:0]     sq_tag;
    logic              sq_active;
    logic [PIX_W-1:0]  mag;
    logic [PIX_W-1:0]  mag_rd;
    logic [PIX_W-1:0]  thresh;

    // a readout waits until every queued magnitude has reached the store
    assign load_busy = r_a_valid || sq_active;
    assign o_pop     = !i_empty && (!i_ctl.is_read || !load_busy);
    assign pop_load  = o_pop && !i_ctl.is_read;
    assign pop_read  = o_pop && i_ctl.is_read;

    assign dx   = (i_pix.pixel >= i_pix.above) ? i_pix.pixel - i_pix.above
                                               : i_pix.above - i_pix.pixel;
    assign dy   = (i_pix.pixel >= i_pix.left) ? i_pix.pixel - i_pix.left
                                              : i_pix.left - i_pix.pixel;
    assign sq_x = SQ_W'(dx) * SQ_W'(dx);
    assign sq_y = SQ_W'(dy) * SQ_W'(dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_r1_valid <= 1'b0;
            r_strobe   <= 1'b0;
            r_max      <= MAX_RST;
            r_min      <= MIN_RST;
        end else begin
            r_a_valid  <= pop_load;
            r_r1_valid <= pop_read;
            r_strobe   <= r_r1_valid;
            if (i_restart || (r_r1_valid && r_r1_last)) begin
                r_max <= MAX_RST;
                r_min <= MIN_RST;
            end else if (sq_valid) begin
                if (mag > r_max) begin
                    r_max <= mag;
                end
                if (mag < r_min) begin
                    r_min <= mag;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_sum       <= {1'b0, sq_x} + {1'b0, sq_y};
        r_a_addr      <= i_addr;
        r_r1_interior <= i_ctl.interior;
        r_r1_last     <= i_ctl.last;
        r_level       <= (r_r1_interior && (mag_rd > thresh)) ? LEVEL_EDGE : LEVEL_BG;
        r_last        <= r_r1_last;
    end

    get_sqrt #(
        .TAG_W (AW)
    ) u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_a_valid),
        .i_value  (r_a_sum),
        .i_tag    (r_a_addr),
        .o_valid  (sq_valid),
        .o_root   (sq_root),
        .o_tag    (sq_tag),
        .o_active (sq_active)
    );

    assign mag    = (sq_root > ROOT_W'(MAG_SAT)) ? MAG_SAT : sq_root[PIX_W-1:0];
    assign thresh = (r_max >= r_min) ? ((r_max - r_min) >> 1) : '0;

    get_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_ROWS * (2 ** $clog2(MAX_COLS)))
    ) u_mag_ram (
        .i_clk   (i_clk),
        .i_we    (sq_valid),
        .i_waddr (sq_tag),
        .i_wdata (mag),
        .i_raddr (i_addr),
        .o_rdata (mag_rd)
    );

    assign o_strobe     = r_strobe;
    assign o_level      = r_level;
    assign o_last_pixel = r_last;

endmodule

/* src/get_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// get_checker
// Port-level checks of the gradient edge threshold unit, bound to the top.
// ----------------------------------------------------------------------------
module get_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_busy,
    input logic       o_strobe,
    input logic [7:0] o_level,
    input logic       o_last_pixel
);
    import get_pkg::*;

    // queue and pipeline come out of reset empty
    assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe && (!i_rst_n || !o_busy))
        else $error("output or busy active right after reset");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_level == LEVEL_EDGE || o_level == LEVEL_BG))
        else $error("level is neither edge nor background");

    // a new frame must be loaded before the next readout word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_pixel |=> !o_strobe ##1 !o_strobe)
        else $error("readout word too soon after the end of a frame");

endmodule

bind gradient_edge_threshold_unit get_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_busy       (o_busy),
    .o_strobe     (o_strobe),
    .o_level      (o_level),
    .o_last_pixel (o_last_pixel)
);

/* test/tb_gradient_edge_threshold_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_edge_threshold_unit
// Self-checking bench for the gradient edge threshold unit.
// ----------------------------------------------------------------------------
// A behavioral copy of the edge detector tracks the frame as command words are
// accepted and queues the level word that each readout must return. A short
// scripted frame covers restart by register write, ignored loads and reads,
// and a saturated magnitude with typed-in results. Random frames of small
// size follow, mostly complete load and readout passes with noise, aborted
// loads and aborted readouts. The sender runs in bursts with random gaps;
// every result word is compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module tb_gradient_edge_threshold_unit;
    import get_pkg::*;

    localparam int ROWS_CAP = 512;
    localparam int COLS_CAP = 512;
    localparam int MAG_DEPTH = ROWS_CAP * COLS_CAP;
    localparam int SETTLE_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned RANDOM_WORDS = 1300;

    typedef struct packed {
        logic [PIX_W-1:0] lvl;
        logic             is_last;
    } level_word_t;

    typedef enum logic [1:0] {
        STEP_SET_ROWS,
        STEP_SET_COLS,
        STEP_LOAD,
        STEP_READ
    } script_kind_t;

    typedef struct packed {
        script_kind_t     kind;
        logic [CFG_W-1:0] val;
        logic             has_word;
        level_word_t      word;
    } script_step_t;

    typedef enum int {
        PAT_NOISE,
        PAT_SPIKES,
        PAT_RAMP,
        PAT_BINARY
    } frame_pattern_t;

    localparam level_word_t NO_WORD = '0;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_op;
    logic [PIX_W-1:0]   i_pixel;
    logic               i_cfg_we;
    logic [CFG_AW-1:0]  i_cfg_addr;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               o_strobe;
    logic [PIX_W-1:0]   o_level;
    logic               o_last_pixel;

    // behavioral copy of the detector
    logic [CFG_W-1:0]   m_rows;
    logic [CFG_W-1:0]   m_cols;
    bit [PIX_W-1:0]     m_above [0:COLS_CAP-1];
    bit [PIX_W-1:0]     m_left;
    bit [PIX_W-1:0]     m_mag [0:MAG_DEPTH-1];
    bit [PIX_W-1:0]     m_hi;
    bit [PIX_W-1:0]     m_lo;
    int unsigned        m_ld_row;
    int unsigned        m_ld_col;
    bit                 m_ready;
    int unsigned        m_rd_pos;

    level_word_t        level_q[$];
    script_step_t       script[$];
    level_word_t        seen_want;
    int unsigned        burst_left;
    int unsigned        useful_words;
    int unsigned        words_seen;
    int unsigned        mismatch_count;
    int unsigned        cycle_count;

    gradient_edge_threshold_unit #(
        .MAX_ROWS(ROWS_CAP),
        .MAX_COLS(COLS_CAP)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .o_busy(o_busy),
        .i_op(i_op),
        .i_pixel(i_pixel),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe),
        .o_level(o_level),
        .o_last_pixel(o_last_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned size_in_use(input logic [CFG_W-1:0] raw,
                                                input int unsigned cap);
        if (raw < 2) return 2;
        if (raw > cap) return cap;
        return raw;
    endfunction

    function automatic int unsigned floor_root(input int unsigned v);
        int unsigned root;
        int unsigned trial;
        root = 0;
        for (int b = 9; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    task automatic restart_model();
        m_ld_row = 0;
        m_ld_col = 0;
        m_ready = 1'b0;
        m_rd_pos = 0;
        m_hi = MAX_RST;
        m_lo = MIN_RST;
    endtask

    task automatic advance_edge_model(input logic op, input logic [PIX_W-1:0] px,
                                      output bit useful, output bit got,
                                      output level_word_t w);
        int unsigned nr;
        int unsigned nc;
        int unsigned mag;
        int unsigned thresh;
        int unsigned r;
        int unsigned c;
        int pix_i;
        int up_i;
        int left_i;
        int dx;
        int dy;
        nr = size_in_use(m_rows, ROWS_CAP);
        nc = size_in_use(m_cols, COLS_CAP);
        useful = 1'b0;
        got = 1'b0;
        w.lvl = LEVEL_BG;
        w.is_last = 1'b0;
        if (op == OP_LOAD) begin
            if (!m_ready) begin
                useful = 1'b1;
                if (m_ld_row >= 1 && m_ld_col >= 1) begin
                    pix_i = px;
                    up_i = m_above[m_ld_col];
                    left_i = m_left;
                    dx = pix_i - up_i;
                    dy = pix_i - left_i;
                    mag = floor_root(dx * dx + dy * dy);
                    if (mag > MAG_SAT) mag = MAG_SAT;
                    m_mag[m_ld_row * COLS_CAP + m_ld_col] = mag[PIX_W-1:0];
                    if (mag > m_hi) m_hi = mag[PIX_W-1:0];
                    if (mag < m_lo) m_lo = mag[PIX_W-1:0];
                end
                m_above[m_ld_col] = px;
                m_left = px;
                if (m_ld_col + 1 >= nc) begin
                    m_ld_col = 0;
                    if (m_ld_row + 1 >= nr) begin
                        m_ld_row = 0;
                        m_ready = 1'b1;
                        m_rd_pos = 0;
                    end else begin
                        m_ld_row++;
                    end
                end else begin
                    m_ld_col++;
                end
            end
        end else if (m_ready) begin
            useful = 1'b1;
            got = 1'b1;
            r = m_rd_pos / nc;
            c = m_rd_pos % nc;
            thresh = (m_hi >= m_lo) ? (m_hi - m_lo) / 2 : 0;
            if (r != 0 && c != 0 && r + 1 < nr && c + 1 < nc) begin
                if (m_mag[r * COLS_CAP + c] > thresh) w.lvl = LEVEL_EDGE;
            end
            w.is_last = (m_rd_pos + 1 >= nr * nc);
            if (w.is_last) restart_model();
            else m_rd_pos++;
        end
    endtask

    task automatic report_fail(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    // sender: bursts of words with random gaps, sometimes none
    task automatic send_word(input logic op, input logic [PIX_W-1:0] px,
                             input bit has_typed, input level_word_t typed);
        int unsigned gap;
        bit useful;
        bit got;
        level_word_t w;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 48);
            if (gap != 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_start <= 1'b1;
        i_op <= op;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        advance_edge_model(op, px, useful, got, w);
        if (got) level_q.push_back(has_typed ? typed : w);
        if (useful) useful_words++;
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        burst_left = 0;
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == REG_ROWS) m_rows = val;
        else m_cols = val;
        restart_model();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_step(input script_kind_t kind, input logic [CFG_W-1:0] val,
                            input logic has_word, input logic [PIX_W-1:0] lvl,
                            input logic is_last);
        script_step_t s;
        s.kind = kind;
        s.val = val;
        s.has_word = has_word;
        s.word.lvl = lvl;
        s.word.is_last = is_last;
        script.push_back(s);
    endtask

    function automatic logic [CFG_W-1:0] small_size();
        if ($urandom_range(0, 9) == 0) return CFG_W'($urandom_range(0, 1));
        return CFG_W'($urandom_range(2, 12));
    endfunction

    function automatic logic [PIX_W-1:0] frame_pixel(input frame_pattern_t pat,
                                                     input int unsigned r,
                                                     input int unsigned c,
                                                     input logic [PIX_W-1:0] base,
                                                     input int unsigned step_r,
                                                     input int unsigned step_c);
        logic [PIX_W-1:0] v;
        case (pat)
            PAT_NOISE:  v = PIX_W'($urandom_range(0, 255));
            PAT_SPIKES: begin
                v = ($urandom_range(0, 5) == 0) ? PIX_W'($urandom_range(0, 255)) : base;
            end
            PAT_RAMP:   v = PIX_W'(base + r * step_r + c * step_c);
            default:    v = $urandom_range(0, 1) ? LEVEL_BG : LEVEL_EDGE;
        endcase
        return v;
    endfunction

    // one frame: optional size writes, load pass, readout pass, with noise
    task automatic frame_pass(input logic [CFG_W-1:0] rv, input logic [CFG_W-1:0] cv,
                              input bit set_rows, input bit set_cols);
        int unsigned nr;
        int unsigned nc;
        int unsigned total;
        int unsigned cut;
        int unsigned step_r;
        int unsigned step_c;
        logic [PIX_W-1:0] base;
        frame_pattern_t pat;
        if (set_rows) write_reg(REG_ROWS, rv);
        if (set_cols) write_reg(REG_COLS, cv);
        nr = size_in_use(m_rows, ROWS_CAP);
        nc = size_in_use(m_cols, COLS_CAP);
        total = nr * nc;
        pat = frame_pattern_t'($urandom_range(0, 3));
        base = PIX_W'($urandom_range(0, 255));
        step_r = $urandom_range(0, 96);
        step_c = $urandom_range(0, 96);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_word(OP_READ, PIX_W'($urandom_range(0, 255)), 0, NO_WORD);
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, total - 1);
            for (int k = 0; k < cut; k++) begin
                send_word(OP_LOAD, PIX_W'($urandom_range(0, 255)), 0, NO_WORD);
            end
            write_reg(REG_COLS, m_cols);
        end
        for (int k = 0; k < total; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_word(OP_READ, PIX_W'($urandom_range(0, 255)), 0, NO_WORD);
            end
            send_word(OP_LOAD, frame_pixel(pat, k / nc, k % nc, base, step_r, step_c),
                      0, NO_WORD);
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_word(OP_LOAD, PIX_W'($urandom_range(0, 255)), 0, NO_WORD);
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(0, total - 1);
            repeat (cut) send_word(OP_READ, PIX_W'($urandom_range(0, 255)), 0, NO_WORD);
            write_reg(REG_ROWS, m_rows);
        end else begin
            repeat (total) send_word(OP_READ, PIX_W'($urandom_range(0, 255)), 0, NO_WORD);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (level_q.size() == 0) begin
                report_fail($sformatf("unexpected word: level=%0d last=%0b",
                                      o_level, o_last_pixel));
            end else begin
                seen_want = level_q.pop_front();
                if (o_level !== seen_want.lvl || o_last_pixel !== seen_want.is_last) begin
                    report_fail($sformatf(
                        "word %0d: expected level=%0d last=%0b, got level=%0d last=%0b",
                        words_seen, seen_want.lvl, seen_want.is_last,
                        o_level, o_last_pixel));
                end
                words_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int unsigned goal;
        int unsigned waited;
        burst_left = 0;
        useful_words = 0;
        words_seen = 0;
        mismatch_count = 0;
        cycle_count = 0;
        m_rows = CFG_W'(CFG_SIZE_RST);
        m_cols = CFG_W'(CFG_SIZE_RST);
        restart_model();
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_op <= OP_LOAD;
        i_pixel <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= REG_ROWS;
        i_cfg_data <= '0;

        // readout before ready, partial frame cut by a size write,
        // 3x3 frame with a saturated center, load while ready
        add_step(STEP_READ, 10'h03C, 0, LEVEL_BG, 0);
        add_step(STEP_LOAD, 10'h0FF, 0, LEVEL_BG, 0);
        add_step(STEP_SET_ROWS, 10'd3, 0, LEVEL_BG, 0);
        add_step(STEP_SET_COLS, 10'd3, 0, LEVEL_BG, 0);
        for (int k = 0; k < 9; k++) begin
            add_step(STEP_LOAD, (k == 4) ? 10'h0FF : 10'h000, 0, LEVEL_BG, 0);
        end
        add_step(STEP_LOAD, 10'h0A5, 0, LEVEL_BG, 0);
        for (int k = 0; k < 9; k++) begin
            add_step(STEP_READ, 10'h05A, 1, (k == 4) ? LEVEL_EDGE : LEVEL_BG, k == 8);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            case (script[i].kind)
                STEP_SET_ROWS: write_reg(REG_ROWS, script[i].val);
                STEP_SET_COLS: write_reg(REG_COLS, script[i].val);
                STEP_LOAD: begin
                    send_word(OP_LOAD, script[i].val[PIX_W-1:0], script[i].has_word,
                              script[i].word);
                end
                default: begin
                    send_word(OP_READ, script[i].val[PIX_W-1:0], script[i].has_word,
                              script[i].word);
                end
            endcase
        end

        goal = useful_words + RANDOM_WORDS;
        while (useful_words < goal) begin
            frame_pass(small_size(), small_size(), $urandom_range(0, 2) != 0,
                       $urandom_range(0, 2) != 0);
        end

        i_start <= 1'b0;
        waited = 0;
        while (level_q.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        if (level_q.size() != 0) begin
            report_fail($sformatf("%0d expected words never arrived", level_q.size()));
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* sim.f */
src/get_pkg.sv
src/get_ram.sv
src/get_fifo.sv
src/get_sqrt.sv
src/get_front.sv
src/get_back.sv
src/gradient_edge_threshold_unit.sv
src/get_checker.sv
test/tb_gradient_edge_threshold_unit.sv
